// ===== rtl/stepper_pulse_ramp_generator_assert.svh =====
// Assertion macros shared by the stepper pulse ramp generator RTL.
`ifndef STEPPER_PULSE_RAMP_GENERATOR_ASSERT_SVH
`define STEPPER_PULSE_RAMP_GENERATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define SPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spr_pkg.sv =====
// Package for the stepper pulse ramp generator: types, codes and constants.
package spr_pkg;

  // Field widths
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned EDGE_W   = 25;
  localparam int unsigned TICK_W   = 17;
  localparam int unsigned STEPS_W  = 24;
  localparam int unsigned PHASE_W  = 3;

  // Configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  // Ramp cadence: fine acceleration and deceleration edge spacing
  localparam int unsigned FINE_ACCEL_EVERY = 100;
  localparam int unsigned DECEL_EVERY      = 50;
  localparam int unsigned MOD100_W = $clog2(FINE_ACCEL_EVERY);
  localparam int unsigned MOD50_W  = $clog2(DECEL_EVERY);

  // Register reset values
  localparam logic [PERIOD_W-1:0] START_PERIOD_RST   = 16'd400;
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST    = 16'd100;
  localparam logic [PERIOD_W-1:0] COARSE_LIMIT_RST   = 16'd200;
  localparam logic [EDGE_W-1:0]   HOLD_EDGES_RST     = 25'd1000;
  localparam logic [EDGE_W-1:0]   SLOWDOWN_EDGES_RST = 25'd50000;

  // Request kinds
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } spr_cmd_e;

  // Ramp phases
  typedef enum logic [PHASE_W-1:0] {
    PH_HOLD  = 3'd0,
    PH_ACCEL = 3'd1,
    PH_FAST  = 3'd2,
    PH_DECEL = 3'd3,
    PH_SLOW  = 3'd4
  } spr_phase_e;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_START_PERIOD   = 3'd0,
    REG_FAST_PERIOD    = 3'd1,
    REG_COARSE_LIMIT   = 3'd2,
    REG_HOLD_EDGES     = 3'd3,
    REG_SLOWDOWN_EDGES = 3'd4
  } spr_reg_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] start_period;
    logic [PERIOD_W-1:0] fast_period;
    logic [PERIOD_W-1:0] coarse_limit;
    logic [EDGE_W-1:0]   hold_edges;
    logic [EDGE_W-1:0]   slowdown_edges;
  } spr_cfg_t;

  typedef struct packed {
    logic                pulse_level;
    logic                busy_res;
    logic                move_done;
    logic [PHASE_W-1:0]  phase;
    logic [PERIOD_W-1:0] current_period;
  } spr_res_t;

endpackage

// ===== rtl/spr_cfg_regs.sv =====
// APB configuration register file for the stepper pulse ramp generator.
module spr_cfg_regs
  import spr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output spr_cfg_t              cfg_o
);

  spr_cfg_t cfg_q, cfg_d;
  spr_reg_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = spr_reg_e'(paddr[4:2]);

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_START_PERIOD:   cfg_d.start_period   = pwdata[PERIOD_W-1:0];
        REG_FAST_PERIOD:    cfg_d.fast_period    = pwdata[PERIOD_W-1:0];
        REG_COARSE_LIMIT:   cfg_d.coarse_limit   = pwdata[PERIOD_W-1:0];
        REG_HOLD_EDGES:     cfg_d.hold_edges     = pwdata[EDGE_W-1:0];
        REG_SLOWDOWN_EDGES: cfg_d.slowdown_edges = pwdata[EDGE_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_START_PERIOD:   prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, cfg_q.start_period};
      REG_FAST_PERIOD:    prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, cfg_q.fast_period};
      REG_COARSE_LIMIT:   prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, cfg_q.coarse_limit};
      REG_HOLD_EDGES:     prdata = {{(APB_DATA_W-EDGE_W){1'b0}}, cfg_q.hold_edges};
      REG_SLOWDOWN_EDGES: prdata = {{(APB_DATA_W-EDGE_W){1'b0}}, cfg_q.slowdown_edges};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_period   <= START_PERIOD_RST;
      cfg_q.fast_period    <= FAST_PERIOD_RST;
      cfg_q.coarse_limit   <= COARSE_LIMIT_RST;
      cfg_q.hold_edges     <= HOLD_EDGES_RST;
      cfg_q.slowdown_edges <= SLOWDOWN_EDGES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/spr_core.sv =====
// Move state, tick counter, edge counter and ramp phase logic.
`include "stepper_pulse_ramp_generator_assert.svh"

module spr_core
  import spr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spr_cfg_t           cfg_i,
  input  logic               step_en_i,
  input  spr_cmd_e           cmd_i,
  input  logic [STEPS_W-1:0] steps_i,
  output spr_res_t           res_o
);

  logic [EDGE_W-1:0]   edge_cnt_q, edge_cnt_d;
  logic [EDGE_W-1:0]   target_q, target_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  spr_phase_e          phase_q, phase_d;
  logic                running_q, running_d;
  logic                pulse_q, pulse_d;
  // Edge count residues, kept alongside the counter to avoid a divider
  logic [MOD100_W-1:0] m100_q, m100_d;
  logic [MOD50_W-1:0]  m50_q, m50_d;

  logic [EDGE_W-1:0]   edge_inc;
  logic [MOD100_W-1:0] m100_inc;
  logic [MOD50_W-1:0]  m50_inc;
  logic [PERIOD_W-1:0] ramp_period;
  spr_phase_e          ramp_phase;
  logic [PERIOD_W-1:0] p_acc, p_dec;
  logic                dec_en, inc_en, done;

  assign edge_inc = edge_cnt_q + 1'b1;
  assign m100_inc = (m100_q == MOD100_W'(FINE_ACCEL_EVERY - 1)) ? '0 : m100_q + 1'b1;
  assign m50_inc  = (m50_q == MOD50_W'(DECEL_EVERY - 1)) ? '0 : m50_q + 1'b1;

  // Phase step for an even edge, using the incremented edge count
  always_comb begin
    dec_en      = (period_q > cfg_i.coarse_limit) || (m100_inc == '0);
    p_acc       = (dec_en && (period_q != '0)) ? period_q - 1'b1 : period_q;
    inc_en      = (m50_inc == '0) && (period_q != '1);
    p_dec       = inc_en ? period_q + 1'b1 : period_q;
    ramp_period = period_q;
    ramp_phase  = phase_q;
    unique case (phase_q)
      PH_HOLD: begin
        ramp_period = cfg_i.start_period;
        if (edge_inc >= cfg_i.hold_edges) begin
          ramp_phase = PH_ACCEL;
        end
      end
      PH_ACCEL: begin
        ramp_period = p_acc;
        if (p_acc <= cfg_i.fast_period) begin
          ramp_period = cfg_i.fast_period;
          ramp_phase  = PH_FAST;
        end
      end
      PH_DECEL: begin
        ramp_period = p_dec;
        if (p_dec >= cfg_i.start_period) begin
          ramp_period = cfg_i.start_period;
          ramp_phase  = PH_SLOW;
        end
      end
      default: begin
        ramp_period = period_q;
      end
    endcase
    // forced slowdown overrides the phase step
    if (edge_inc > cfg_i.slowdown_edges) begin
      ramp_phase = PH_DECEL;
    end
  end

  // Next state for one request
  always_comb begin
    edge_cnt_d = edge_cnt_q;
    target_d   = target_q;
    tick_d     = tick_q;
    period_d   = period_q;
    phase_d    = phase_q;
    running_d  = running_q;
    pulse_d    = pulse_q;
    m100_d     = m100_q;
    m50_d      = m50_q;
    done       = 1'b0;
    if (step_en_i) begin
      if (cmd_i == CMD_START) begin
        if (!running_q) begin
          target_d   = {steps_i, 1'b0};
          edge_cnt_d = '0;
          tick_d     = '0;
          m100_d     = '0;
          m50_d      = '0;
          period_d   = cfg_i.start_period;
          phase_d    = PH_HOLD;
          pulse_d    = 1'b1;
          running_d  = (steps_i != '0);
        end
      end else if (running_q) begin
        tick_d = tick_q + 1'b1;
        if (tick_q >= {1'b0, period_q}) begin
          tick_d     = '0;
          edge_cnt_d = edge_inc;
          m100_d     = m100_inc;
          m50_d      = m50_inc;
          pulse_d    = edge_inc[0];
          if (!edge_inc[0]) begin
            period_d = ramp_period;
            phase_d  = ramp_phase;
          end
          if (edge_inc >= target_q) begin
            running_d = 1'b0;
            done      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_cnt_q <= '0;
      target_q   <= '0;
      tick_q     <= '0;
      period_q   <= START_PERIOD_RST;
      phase_q    <= PH_HOLD;
      running_q  <= 1'b0;
      pulse_q    <= 1'b0;
      m100_q     <= '0;
      m50_q      <= '0;
    end else begin
      edge_cnt_q <= edge_cnt_d;
      target_q   <= target_d;
      tick_q     <= tick_d;
      period_q   <= period_d;
      phase_q    <= phase_d;
      running_q  <= running_d;
      pulse_q    <= pulse_d;
      m100_q     <= m100_d;
      m50_q      <= m50_d;
    end
  end

  // Result reflects the state after this request
  always_comb begin
    res_o.pulse_level    = pulse_d;
    res_o.busy_res       = running_d;
    res_o.move_done      = done;
    res_o.phase          = phase_d;
    res_o.current_period = period_d;
  end

  `SPR_ASSERT_NEXT(a_start_clears,
    step_en_i && (cmd_i == CMD_START) && !running_q,
    (edge_cnt_q == '0) && (tick_q == '0) && (m100_q == '0) && (m50_q == '0) && pulse_q,
    "start did not clear the move counters")
  `SPR_ASSERT_NEXT(a_idle_tick_holds,
    step_en_i && (cmd_i == CMD_TICK) && !running_q,
    $stable(edge_cnt_q) && $stable(period_q) && $stable(phase_q) && $stable(pulse_q),
    "tick while idle changed the move state")
  `SPR_ASSERT_NOW(a_running_below_target,
    running_q,
    edge_cnt_q < target_q,
    "move still running at or past its target edge count")

endmodule

// ===== rtl/stepper_pulse_ramp_generator.sv =====
// Top level of the stepper pulse ramp generator: stream stages and config port.
// Each request is held in the input stage; its result is registered in the output stage.
// Throughput: one request per cycle when not stalled; the core's state update sets this.
// A stalled output holds its result and back-pressures the input one stage deep.
// Reset (rst_ni low, asynchronous) clears both stages, the move state and the
// registers to their defaults; the block accepts requests as soon as reset is released.
`include "stepper_pulse_ramp_generator_assert.svh"

module stepper_pulse_ramp_generator
  import spr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // [23:0] step_count
  input  logic                  s_axis_tuser,  // [0] command
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // [0] pulse_level, [1] busy_res,
                                               // [4:2] phase, [20:5] current_period
  output logic                  m_axis_tlast,  // move_done
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  spr_cfg_t           cfg;
  spr_res_t           res;
  logic               in_v_q, in_v_d;
  spr_cmd_e           in_cmd_q;
  logic [STEPS_W-1:0] in_steps_q;
  logic               out_v_q, out_v_d;
  spr_res_t           out_res_q;
  logic               s_acc, adv, step_en;

  spr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage handshake: the input stage moves on whenever the result slot is free
  assign adv           = !out_v_q || m_axis_tready;
  assign step_en       = in_v_q && adv;
  assign s_axis_tready = !in_v_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_v_d = in_v_q;
    if (s_acc) begin
      in_v_d = 1'b1;
    end else if (adv) begin
      in_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (step_en) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_cmd_q   <= spr_cmd_e'(s_axis_tuser);
      in_steps_q <= s_axis_tdata[STEPS_W-1:0];
    end
    if (step_en) begin
      out_res_q <= res;
    end
  end

  spr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_en_i (step_en),
    .cmd_i     (in_cmd_q),
    .steps_i   (in_steps_q),
    .res_o     (res)
  );

  // Result packing
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_res_q.move_done;
  assign m_axis_tdata  = {3'b000, out_res_q.current_period, out_res_q.phase,
                          out_res_q.busy_res, out_res_q.pulse_level};

  `SPR_ASSERT_NOW(a_done_not_busy,
    m_axis_tvalid && m_axis_tlast,
    !m_axis_tdata[1],
    "move_done reported while still busy")

endmodule
